>>> rtl/core/fawlm_pkg.sv
// fawlm_pkg: shared types and constants for the frame average window level map
// depends on nothing
package fawlm_pkg;

  localparam int PIX_W   = 32;
  localparam int MEAN_W  = 40;
  localparam int IDX_W   = 8;
  localparam int CNT_W   = 16;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [CFG_IW-1:0] REG_AUTO_SCALE = 3'd0;
  localparam logic [CFG_IW-1:0] REG_AUTO_MIN   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_AUTO_MAX   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SLIDER_MIN = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SLIDER_MAX = 3'd4;
  localparam logic [CFG_IW-1:0] REG_ACC_ON     = 3'd5;
  localparam logic [CFG_IW-1:0] REG_PPF        = 3'd6;

  localparam logic [IDX_W-1:0] IDX_LOW  = 8'd1;
  localparam logic [IDX_W-1:0] IDX_HIGH = 8'd254;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV_MEAN,
    ST_DIV_LEVEL,
    ST_OUT
  } state_t;

  // divider request/response
  typedef struct packed {
    logic              start;
    logic signed [63:0] num;
    logic signed [47:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] quo;
    logic signed [63:0] rem;
  } div_rsp_t;

endpackage

>>> rtl/core/fawlm_div.sv
// fawlm_div: shared iterative signed divider, one quotient bit per cycle
// depends on fawlm_pkg; truncates toward zero, remainder takes sign of numerator
module fawlm_div
  import fawlm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] quo_r, quo_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [47:0] den_r, den_nxt;
  logic        nneg_r, nneg_nxt, qneg_r, qneg_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;
  logic [63:0] shifted;

  // restoring step
  always_comb begin
    shifted  = {rem_r[62:0], quo_r[63]};
    trial    = {1'b0, shifted} - {17'd0, den_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    nneg_nxt = nneg_r;
    qneg_nxt = qneg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.num[63] ? 64'(-req.num) : req.num;
      rem_nxt  = '0;
      den_nxt  = req.den[47] ? 48'(-req.den) : req.den;
      nneg_nxt = req.num[63];
      qneg_nxt = req.num[63] ^ req.den[47];
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    nneg_r <= nneg_nxt;
    qneg_r <= qneg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = qneg_r ? 64'(-quo_r) : quo_r;
  assign rsp.rem  = nneg_r ? 64'(-rem_r) : rem_r;

endmodule

>>> rtl/core/fawlm_mem.sv
// fawlm_mem: per-pixel mean store, one write and one registered read port
// depends on fawlm_pkg
module fawlm_mem
  import fawlm_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [MEAN_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [MEAN_W-1:0] rd_data
);

  logic [MEAN_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/frame_average_window_level_map.sv
// frame_average_window_level_map: running per-pixel frame mean plus window/level
// flow: input transfer, memory read when accumulating, then one or two 64-step divider
// passes (mean, then level) and the output register; no level pass when the range is zero
// throughput: a new pixel is taken only once the last result has left the output register
// reset: synchronous active-low rst_n clears control, counters and configuration registers;
// payload registers and mean store contents are undefined until written
module frame_average_window_level_map
  import fawlm_pkg::*;
#(
  parameter int MAX_PIXELS = 65536
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IW-1:0]        cfg_index,
  input  logic [CFG_DW-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [PIX_W-1:0]  in_pixel_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         out_palette_index,
  output logic signed [PIX_W-1:0]  out_shown_value,
  output logic                     out_frame_last
);

  localparam int AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int POS_W = $clog2(MAX_PIXELS + 1) + 1;
  localparam int PPF_W = 17;

  // configuration registers
  logic                    auto_scale_r, acc_on_r;
  logic signed [PIX_W-1:0] auto_min_r, auto_max_r;
  logic [15:0]             slider_min_r, slider_max_r;
  logic [PPF_W-1:0]        ppf_r;

  logic [CNT_W-1:0] frame_cnt_r, frame_cnt_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  state_t state_r, state_nxt;

  logic signed [PIX_W-1:0]  pix_r;
  logic [AW-1:0]            addr_r;
  logic                     last_r;
  logic signed [PIX_W-1:0]  shown_r, shown_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     ovalid_r, ovalid_nxt;
  logic signed [63:0]       num_r, num_nxt;
  logic signed [47:0]       den_r, den_nxt;

  logic [MEAN_W-1:0] rd_data;
  logic              wr_en;
  logic [MEAN_W-1:0] wr_data;

  div_req_t dreq;
  div_rsp_t drsp;

  logic [POS_W-1:0]   fsize;
  logic               take;
  logic [CNT_W-1:0]   n_eff;
  logic signed [47:0] lo, range_v;
  logic signed [47:0] dv;
  logic signed [63:0] lvl_num;
  logic signed [PIX_W-1:0] lvl_src;
  logic signed [63:0] q_adj;
  logic signed [MEAN_W-1:0] mean_q;
  logic signed [MEAN_W-1:0] shown_full;
  logic signed [MEAN_W-1:0] old_v;
  logic signed [63:0] prod;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_scale_r <= 1'b0;
      auto_min_r   <= '0;
      auto_max_r   <= '0;
      slider_min_r <= '0;
      slider_max_r <= 16'd300;
      acc_on_r     <= 1'b0;
      ppf_r        <= 17'h10000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AUTO_SCALE: auto_scale_r <= cfg_data[0];
        REG_AUTO_MIN:   auto_min_r   <= cfg_data;
        REG_AUTO_MAX:   auto_max_r   <= cfg_data;
        REG_SLIDER_MIN: slider_min_r <= cfg_data[15:0];
        REG_SLIDER_MAX: slider_max_r <= cfg_data[15:0];
        REG_ACC_ON:     acc_on_r     <= cfg_data[0];
        REG_PPF:        ppf_r        <= cfg_data[PPF_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    if (ppf_r == '0 || 32'(ppf_r) > 32'(MAX_PIXELS)) begin
      fsize = POS_W'(MAX_PIXELS);
    end else begin
      fsize = POS_W'(ppf_r);
    end
  end

  assign take     = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE) && !ovalid_r;

  // position and frame counter
  always_comb begin
    pos_nxt       = pos_r;
    frame_cnt_nxt = frame_cnt_r;
    if (take) begin
      pos_nxt = (pos_r + POS_W'(1) >= fsize) ? '0 : pos_r + POS_W'(1);
      if (acc_on_r && pos_r == '0 && frame_cnt_r != '1) begin
        frame_cnt_nxt = frame_cnt_r + CNT_W'(1);
      end
    end
    if (cfg_we && cfg_index == REG_ACC_ON) begin
      frame_cnt_nxt = '0;
    end
  end

  assign n_eff = (frame_cnt_r == '0) ? CNT_W'(1) : frame_cnt_r;

  // window bounds
  always_comb begin
    if (auto_scale_r) begin
      lo      = 48'(auto_min_r);
      range_v = 48'(auto_max_r) - 48'(auto_min_r);
    end else begin
      lo      = 48'($signed({1'b0, slider_min_r}));
      range_v = 48'($signed({1'b0, slider_max_r})) - 48'($signed({1'b0, slider_min_r}));
    end
  end

  // first frame overwrites, so the stored value is not needed there
  assign old_v = (n_eff == CNT_W'(1)) ? '0 : $signed(rd_data);

  // (n-1)*old + pix*256, single 40x17 product
  assign prod = 64'(old_v) * 64'($signed({1'b0, n_eff - CNT_W'(1)}))
              + (64'(pix_r) <<< 8);

  assign mean_q     = MEAN_W'(drsp.quo);
  assign shown_full = mean_q / 256;

  // level numerator from the raw pixel or the new mean
  assign lvl_src = (state_r == ST_IDLE) ? in_pixel_value : PIX_W'(shown_full);

  always_comb begin
    dv      = 48'(lvl_src) - lo;
    lvl_num = 64'(dv) <<< 8;
  end

  // rounding of the level quotient
  always_comb begin
    q_adj = drsp.quo;
    if (drsp.rem != '0 && ((num_r > 0) == (den_r > 0))) begin
      q_adj = drsp.quo + 64'sd1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (take) state_nxt = acc_on_r ? ST_READ : ST_DIV_LEVEL;
      ST_READ:      state_nxt = ST_DIV_MEAN;
      ST_DIV_MEAN:  if (drsp.done) state_nxt = ST_DIV_LEVEL;
      ST_DIV_LEVEL: if (drsp.done || (den_r == '0 && !dreq.start)) state_nxt = ST_OUT;
      ST_OUT:       state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    shown_nxt  = shown_r;
    idx_nxt    = idx_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    ovalid_nxt = ovalid_r;
    dreq       = '0;
    wr_en      = 1'b0;
    wr_data    = '0;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (take && !acc_on_r) begin
          shown_nxt  = in_pixel_value;
          num_nxt    = lvl_num;
          den_nxt    = range_v;
          dreq.start = (range_v != '0);
          dreq.num   = lvl_num;
          dreq.den   = range_v;
          idx_nxt    = (dv > 0) ? IDX_HIGH : IDX_LOW;
        end
      end
      ST_READ: begin
        dreq.start = 1'b1;
        dreq.num   = prod;
        dreq.den   = 48'($signed({1'b0, n_eff}));
      end
      ST_DIV_MEAN: begin
        if (drsp.done) begin
          wr_en      = 1'b1;
          wr_data    = mean_q;
          shown_nxt  = PIX_W'(shown_full);
          num_nxt    = lvl_num;
          den_nxt    = range_v;
          dreq.start = (range_v != '0);
          dreq.num   = lvl_num;
          dreq.den   = range_v;
          idx_nxt    = (lvl_num > 0) ? IDX_HIGH : IDX_LOW;
        end
      end
      ST_DIV_LEVEL: begin
        if (drsp.done) begin
          if (q_adj <= 0)        idx_nxt = IDX_LOW;
          else if (q_adj >= 255) idx_nxt = IDX_HIGH;
          else                   idx_nxt = IDX_W'(q_adj);
        end
      end
      ST_OUT: ovalid_nxt = 1'b1;
      default: ;
    endcase
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ovalid_r    <= 1'b0;
      pos_r       <= '0;
      frame_cnt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      ovalid_r    <= ovalid_nxt;
      pos_r       <= pos_nxt;
      frame_cnt_r <= frame_cnt_nxt;
    end
    shown_r <= shown_nxt;
    idx_r   <= idx_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    if (take) begin
      pix_r  <= in_pixel_value;
      addr_r <= AW'(pos_r);
      last_r <= (pos_r + POS_W'(1) >= fsize);
    end
  end

  fawlm_mem #(.DEPTH(MAX_PIXELS), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr_r),
    .wr_data (wr_data),
    .rd_addr (take ? AW'(pos_r) : addr_r),
    .rd_data (rd_data)
  );

  fawlm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign out_valid         = ovalid_r;
  assign out_palette_index = idx_r;
  assign out_shown_value   = shown_r;
  assign out_frame_last    = last_r;

endmodule

>>> bench/tb_frame_average_window_level_map.sv
// tb_frame_average_window_level_map: self-checking bench for the frame average
// window level map; predicts every transfer with its own running-mean model
// depends on fawlm_pkg and frame_average_window_level_map
module tb_frame_average_window_level_map;
  timeunit 1ns;
  timeprecision 1ps;
  import fawlm_pkg::*;

  localparam int FRAME_MAX = 65536;

  typedef struct {
    logic [IDX_W-1:0]        index;
    logic signed [PIX_W-1:0] shown;
    logic                    last;
  } pix_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IW-1:0]       cfg_index;
  logic [CFG_DW-1:0]       cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [PIX_W-1:0] in_pixel_value;
  logic                    out_valid;
  logic                    out_ready;
  logic [IDX_W-1:0]        out_palette_index;
  logic signed [PIX_W-1:0] out_shown_value;
  logic                    out_frame_last;

  frame_average_window_level_map i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel_value(in_pixel_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_palette_index(out_palette_index), .out_shown_value(out_shown_value),
    .out_frame_last(out_frame_last)
  );

  // shadow registers and state of the predictor
  logic              sh_auto_scale;
  logic signed [31:0] sh_auto_min;
  logic signed [31:0] sh_auto_max;
  logic [15:0]       sh_slider_min;
  logic [15:0]       sh_slider_max;
  logic              sh_acc_on;
  logic [16:0]       sh_ppf;
  longint            mean_mem [int];
  int unsigned       frame_cnt;
  int unsigned       pix_pos;

  pix_result_t       pending_q[$];
  int                error_count;
  bit                quiet_in;
  bit                quiet_out;
  int                hold_left;
  bit                hold_go;
  bit                hold_go_d;
  int                stall_left;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // window/level mapping of one shown value
  function automatic logic [IDX_W-1:0] level_of(input longint v);
    longint lo, range, num, q, r;
    if (sh_auto_scale) begin
      lo = sh_auto_min;
      range = longint'(sh_auto_max) - lo;
    end else begin
      lo = sh_slider_min;
      range = longint'(sh_slider_max) - longint'(sh_slider_min);
    end
    if (range == 0) return (v - lo > 0) ? IDX_HIGH : IDX_LOW;
    num = (v - lo) * 256;
    q = num / range;
    r = num % range;
    if (r != 0 && ((num > 0) == (range > 0))) q++;
    if (q <= 0) return IDX_LOW;
    if (q >= 255) return IDX_HIGH;
    return q[IDX_W-1:0];
  endfunction

  // advance the frame-mean model by one pixel and queue its result
  function automatic void predict_pixel(input logic signed [PIX_W-1:0] pix);
    int unsigned size;
    longint n, old, m, shown;
    pix_result_t res;
    size = (sh_ppf == 0 || sh_ppf > FRAME_MAX) ? FRAME_MAX : int'(sh_ppf);
    res.last = (pix_pos + 1 >= size);
    if (sh_acc_on) begin
      if (pix_pos == 0 && frame_cnt < 65535) frame_cnt++;
      n = (frame_cnt == 0) ? 1 : frame_cnt;
      old = mean_mem.exists(pix_pos) ? mean_mem[pix_pos] : 0;
      m = ((n - 1) * old + longint'(pix) * 256) / n;
      mean_mem[pix_pos] = m;
      shown = m / 256;
    end else begin
      shown = pix;
    end
    pix_pos = res.last ? 0 : pix_pos + 1;
    res.shown = shown[PIX_W-1:0];
    res.index = level_of(shown);
    pending_q = {pending_q, res};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(15);
    if (r < 10) return 0;
    if (r < 15) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // one register write, mirrored in the shadow copy
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_AUTO_SCALE: sh_auto_scale = val[0];
      REG_AUTO_MIN:   sh_auto_min = val;
      REG_AUTO_MAX:   sh_auto_max = val;
      REG_SLIDER_MIN: sh_slider_min = val[15:0];
      REG_SLIDER_MAX: sh_slider_max = val[15:0];
      REG_ACC_ON: begin
        sh_acc_on = val[0];
        frame_cnt = 0;
      end
      REG_PPF:        sh_ppf = val[16:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // offer one pixel and wait for its transfer
  task automatic send_pixel(input logic signed [PIX_W-1:0] pix);
    int gap;
    gap = quiet_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_value <= pix;
    do @(posedge clk); while (!in_ready);
    predict_pixel(pix);
  endtask

  // block is idle once every result is back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [PIX_W-1:0] rand_pixel();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(400);
      2: return -$signed($urandom_range(1000));
      3: return $urandom_range(70000);
      4: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed(sh_auto_min) + $signed($urandom_range(512)) - 256;
    endcase
  endfunction

  // receiver stalls, short and long, plus a requested long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet_out && $urandom_range(3) == 0) stall_left <= pick_gap();
    end
  end

  // hold-off counter, started on a rising hold request
  always @(posedge clk) begin
    hold_go_d <= hold_go;
    if (hold_go && !hold_go_d) begin
      hold_left <= 3000;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result check on each output transfer
  always @(posedge clk) begin
    pix_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        exp_res = pending_q.pop_front();
        if (out_palette_index !== exp_res.index)
          report_mismatch($sformatf("palette_index %0d, expected %0d",
                                    out_palette_index, exp_res.index));
        if (out_shown_value !== exp_res.shown)
          report_mismatch($sformatf("shown_value %0d, expected %0d",
                                    out_shown_value, exp_res.shown));
        if (out_frame_last !== exp_res.last)
          report_mismatch($sformatf("frame_last %0b, expected %0b",
                                    out_frame_last, exp_res.last));
      end
    end
  end

  // window extremes, zero and negative range, wide auto range
  task automatic test_window_level();
    send_pixel(0);
    send_pixel(1);
    send_pixel(150);
    send_pixel(300);
    send_pixel(301);
    send_pixel(-1);
    send_pixel(32'sh7fffffff);
    send_pixel(32'sh80000000);
    settle();
    write_reg(REG_SLIDER_MIN, 32'd1000);
    write_reg(REG_SLIDER_MAX, 32'd10);
    send_pixel(500);
    send_pixel(0);
    send_pixel(2000);
    settle();
    write_reg(REG_SLIDER_MIN, 32'd65535);
    write_reg(REG_SLIDER_MAX, 32'd65535);
    send_pixel(65535);
    send_pixel(65536);
    settle();
    write_reg(REG_AUTO_SCALE, 32'd1);
    write_reg(REG_AUTO_MIN, 32'h80000000);
    write_reg(REG_AUTO_MAX, 32'h7fffffff);
    send_pixel(32'sh80000000);
    send_pixel(32'sh7fffffff);
    send_pixel(0);
    settle();
    write_reg(REG_AUTO_MIN, 32'd5);
    write_reg(REG_AUTO_MAX, 32'd5);
    send_pixel(4);
    send_pixel(5);
    send_pixel(6);
    settle();
  endtask

  // frame size edge cases and shrinking past the position
  task automatic test_frame_size();
    write_reg(REG_PPF, 32'd0);
    send_pixel(7);
    send_pixel(8);
    settle();
    write_reg(REG_PPF, 32'h1ffff);
    send_pixel(9);
    settle();
    write_reg(REG_PPF, 32'd10);
    repeat (7) send_pixel($urandom_range(300));
    settle();
    write_reg(REG_PPF, 32'd4);
    repeat (3) send_pixel($urandom_range(300));
    settle();
    write_reg(REG_PPF, 32'd1);
    repeat (3) send_pixel($urandom_range(300));
    settle();
  endtask

  // averaging, enabled mid-frame
  task automatic test_accumulate();
    write_reg(REG_PPF, 32'd6);
    write_reg(REG_AUTO_SCALE, 32'd0);
    write_reg(REG_SLIDER_MIN, 32'd0);
    write_reg(REG_SLIDER_MAX, 32'd300);
    repeat (2) send_pixel(100);
    settle();
    write_reg(REG_ACC_ON, 32'd1);
    repeat (20) send_pixel($urandom_range(1) ? 32'sh7fffffff : 32'sh80000000);
    repeat (12) send_pixel($urandom_range(300));
    settle();
  endtask

  // long receiver hold while the sender keeps offering
  task automatic test_backpressure();
    quiet_in = 1'b1;
    hold_go = 1'b1;
    repeat (30) send_pixel(rand_pixel());
    settle();
    hold_go = 1'b0;
    quiet_in = 1'b0;
  endtask

  // random phases of configuration and pixel traffic
  task automatic test_random();
    int phase, k, count;
    for (phase = 0; phase < 30; phase++) begin
      quiet_in = ($urandom_range(4) == 0);
      quiet_out = ($urandom_range(4) == 0);
      if ($urandom_range(2) == 0) begin
        // frame size changes only with averaging off so no unwritten entry is read
        write_reg(REG_ACC_ON, 32'd0);
        case ($urandom_range(9))
          0: write_reg(REG_PPF, 32'd0);
          1: write_reg(REG_PPF, $urandom_range(32'h1ffff, 32'h10000));
          default: write_reg(REG_PPF, $urandom_range(32, 1));
        endcase
      end
      if ($urandom_range(2) == 0) write_reg(REG_ACC_ON, $urandom_range(1));
      write_reg(REG_AUTO_SCALE, $urandom_range(1));
      write_reg(REG_AUTO_MIN, $urandom_range(1) ? $urandom : $urandom_range(200));
      write_reg(REG_AUTO_MAX, $urandom_range(1) ? $urandom : $urandom_range(400, 100));
      write_reg(REG_SLIDER_MIN, $urandom_range(3) == 0 ? $urandom : $urandom_range(200));
      write_reg(REG_SLIDER_MAX, $urandom_range(3) == 0 ? $urandom : $urandom_range(500));
      count = $urandom_range(80, 40);
      for (k = 0; k < count; k++) send_pixel(rand_pixel());
      settle();
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_pixel_value = '0;
    hold_go = 1'b0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    error_count = 0;
    sh_auto_scale = 1'b0;
    sh_auto_min = '0;
    sh_auto_max = '0;
    sh_slider_min = '0;
    sh_slider_max = 16'd300;
    sh_acc_on = 1'b0;
    sh_ppf = 17'd65536;
    frame_cnt = 0;
    pix_pos = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_window_level();
    test_frame_size();
    test_accumulate();
    test_backpressure();
    test_random();
    settle();
    repeat (200) @(posedge clk);
    if (error_count == 0 && pending_q.size() == 0) begin
      $display("tb_frame_average_window_level_map: clean");
    end else begin
      $display("tb_frame_average_window_level_map: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #30ms;
    $display("tb_frame_average_window_level_map: errors");
    $finish;
  end

endmodule
